// ===== sv/asbmd_pkg.sv =====
// shared types and constants for the add/sub/multiply/divide unit
`default_nettype none

package asbmd_pkg;

  localparam int WIDTH_DEF = 12;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  // per-item control that travels with the operands
  typedef struct packed {
    func_t func;
    logic  prev;  // booth trailing bit
    logic  ovf;   // signed overflow of add/sub
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/asbmd_front.sv =====
// front end: takes the command, decodes it and prepares the working registers
`default_nettype none

module asbmd_front #(
  parameter int WIDTH = asbmd_pkg::WIDTH_DEF
) (
  input  wire logic               start,
  input  wire logic               q_full,
  input  wire logic [1:0]         in_func,
  input  wire logic [WIDTH-1:0]   in_operand_a,
  input  wire logic [WIDTH-1:0]   in_operand_b,
  output logic                    busy,
  output logic                    push,
  output asbmd_pkg::ctl_t         push_ctl,
  output logic [WIDTH-1:0]        push_acc,
  output logic [WIDTH-1:0]        push_mq,
  output logic [WIDTH-1:0]        push_bop
);
  import asbmd_pkg::*;

  func_t            func;
  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] sum;
  logic             sa;
  logic             sb;
  logic             sr;

  assign func   = func_t'(in_func);
  assign busy   = q_full;
  assign push   = start && !q_full;

  assign addend = (func == FUNC_SUB) ? (~in_operand_b + {{(WIDTH-1){1'b0}}, 1'b1})
                                     : in_operand_b;
  assign sum    = in_operand_a + addend;
  assign sa     = in_operand_a[WIDTH-1];
  assign sb     = in_operand_b[WIDTH-1];
  assign sr     = sum[WIDTH-1];

  always_comb begin
    push_ctl.func = func;
    push_ctl.prev = 1'b0;
    push_ctl.ovf  = 1'b0;
    push_acc      = '0;
    push_mq       = in_operand_a;
    push_bop      = in_operand_b;
    unique case (func)
      FUNC_ADD: begin
        push_mq      = sum;
        push_ctl.ovf = (sa == sb) && (sr != sa);
      end
      FUNC_SUB: begin
        push_mq      = sum;
        push_ctl.ovf = (sa != sb) && (sr != sa);
      end
      FUNC_MUL: begin
        push_mq = in_operand_a;
      end
      FUNC_DIV: begin
        push_mq = in_operand_a;
      end
      default: begin
        push_mq = in_operand_a;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/asbmd_queue.sv =====
// short fifo that decouples the front end from the step pipeline
`default_nettype none

module asbmd_queue #(
  parameter int WIDTH = asbmd_pkg::WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire asbmd_pkg::ctl_t    push_ctl,
  input  wire logic [WIDTH-1:0]   push_acc,
  input  wire logic [WIDTH-1:0]   push_mq,
  input  wire logic [WIDTH-1:0]   push_bop,
  output logic                    full,
  output logic                    pop,
  output asbmd_pkg::ctl_t         pop_ctl,
  output logic [WIDTH-1:0]        pop_acc,
  output logic [WIDTH-1:0]        pop_mq,
  output logic [WIDTH-1:0]        pop_bop
);
  import asbmd_pkg::*;

  ctl_t             ctl_mem [Q_DEPTH];
  logic [WIDTH-1:0] acc_mem [Q_DEPTH];
  logic [WIDTH-1:0] mq_mem  [Q_DEPTH];
  logic [WIDTH-1:0] bop_mem [Q_DEPTH];

  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_nxt;
  logic [Q_CW-1:0]  count_r;
  logic [Q_CW-1:0]  count_nxt;

  // the back end never stalls, so any waiting entry leaves at once
  assign pop  = (count_r != '0);
  assign full = (count_r == Q_CW'(Q_DEPTH));

  assign pop_ctl = ctl_mem[rd_ptr_r];
  assign pop_acc = acc_mem[rd_ptr_r];
  assign pop_mq  = mq_mem[rd_ptr_r];
  assign pop_bop = bop_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr_r] <= push_ctl;
      acc_mem[wr_ptr_r] <= push_acc;
      mq_mem[wr_ptr_r]  <= push_mq;
      bop_mem[wr_ptr_r] <= push_bop;
    end
  end

endmodule

`default_nettype wire

// ===== sv/asbmd_step.sv =====
// one booth or restoring-division step; add/sub items pass unchanged
`default_nettype none

module asbmd_step #(
  parameter int WIDTH = asbmd_pkg::WIDTH_DEF
) (
  input  wire asbmd_pkg::ctl_t    ctl_i,
  input  wire logic [WIDTH-1:0]   acc_i,
  input  wire logic [WIDTH-1:0]   mq_i,
  input  wire logic [WIDTH-1:0]   bop_i,
  output asbmd_pkg::ctl_t         ctl_o,
  output logic [WIDTH-1:0]        acc_o,
  output logic [WIDTH-1:0]        mq_o
);
  import asbmd_pkg::*;

  logic             cur;
  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] bsum;
  logic [WIDTH:0]   part;
  logic [WIDTH:0]   diff;
  logic             fits;

  // booth recoding of the current and trailing multiplier bits
  assign cur = mq_i[0];
  always_comb begin
    if (cur && !ctl_i.prev) begin
      addend = ~bop_i + {{(WIDTH-1){1'b0}}, 1'b1};
    end else if (!cur && ctl_i.prev) begin
      addend = bop_i;
    end else begin
      addend = '0;
    end
  end
  assign bsum = acc_i + addend;

  // restoring step: shift in the next dividend bit and try the divisor
  assign part = {acc_i, mq_i[WIDTH-1]};
  assign fits = (part >= {1'b0, bop_i});
  assign diff = part - {1'b0, bop_i};

  always_comb begin
    ctl_o = ctl_i;
    acc_o = acc_i;
    mq_o  = mq_i;
    unique case (ctl_i.func)
      FUNC_MUL: begin
        ctl_o.prev = cur;
        mq_o       = {bsum[0], mq_i[WIDTH-1:1]};
        acc_o      = {bsum[WIDTH-1], bsum[WIDTH-1:1]};
      end
      FUNC_DIV: begin
        mq_o  = {mq_i[WIDTH-2:0], fits};
        acc_o = fits ? diff[WIDTH-1:0] : part[WIDTH-1:0];
      end
      FUNC_ADD, FUNC_SUB: begin
        mq_o = mq_i;
      end
      default: begin
        mq_o = mq_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/asbmd_back.sv =====
// back end: WIDTH registered step stages and the result strobe
`default_nettype none

module asbmd_back #(
  parameter int WIDTH = asbmd_pkg::WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire asbmd_pkg::ctl_t    in_ctl,
  input  wire logic [WIDTH-1:0]   in_acc,
  input  wire logic [WIDTH-1:0]   in_mq,
  input  wire logic [WIDTH-1:0]   in_bop,
  output logic                    out_strobe,
  output logic [WIDTH-1:0]        out_result,
  output logic [WIDTH-1:0]        out_remainder,
  output logic                    out_overflow
);
  import asbmd_pkg::*;

  logic             vld_r   [WIDTH];
  ctl_t             ctl_r   [WIDTH];
  logic [WIDTH-1:0] acc_r   [WIDTH];
  logic [WIDTH-1:0] mq_r    [WIDTH];
  logic [WIDTH-1:0] bop_r   [WIDTH];

  logic             st_vld  [WIDTH];
  ctl_t             st_ctl  [WIDTH];
  logic [WIDTH-1:0] st_acc  [WIDTH];
  logic [WIDTH-1:0] st_mq   [WIDTH];
  logic [WIDTH-1:0] st_bop  [WIDTH];

  ctl_t             ctl_nxt [WIDTH];
  logic [WIDTH-1:0] acc_nxt [WIDTH];
  logic [WIDTH-1:0] mq_nxt  [WIDTH];

  for (genvar i = 0; i < WIDTH; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign st_vld[i] = in_vld;
      assign st_ctl[i] = in_ctl;
      assign st_acc[i] = in_acc;
      assign st_mq[i]  = in_mq;
      assign st_bop[i] = in_bop;
    end else begin : g_next
      assign st_vld[i] = vld_r[i-1];
      assign st_ctl[i] = ctl_r[i-1];
      assign st_acc[i] = acc_r[i-1];
      assign st_mq[i]  = mq_r[i-1];
      assign st_bop[i] = bop_r[i-1];
    end

    asbmd_step #(
      .WIDTH (WIDTH)
    ) u_step (
      .ctl_i (st_ctl[i]),
      .acc_i (st_acc[i]),
      .mq_i  (st_mq[i]),
      .bop_i (st_bop[i]),
      .ctl_o (ctl_nxt[i]),
      .acc_o (acc_nxt[i]),
      .mq_o  (mq_nxt[i])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= st_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      ctl_r[i] <= ctl_nxt[i];
      acc_r[i] <= acc_nxt[i];
      mq_r[i]  <= mq_nxt[i];
      bop_r[i] <= st_bop[i];
    end
  end

  // last stage register is the result register
  assign out_strobe    = vld_r[WIDTH-1];
  assign out_result    = mq_r[WIDTH-1];
  assign out_remainder = (ctl_r[WIDTH-1].func == FUNC_DIV) ? acc_r[WIDTH-1] : '0;
  assign out_overflow  = ctl_r[WIDTH-1].ovf;

endmodule

`default_nettype wire

// ===== sv/add_sub_booth_mul_restoring_div_unit.sv =====
// top level of the add/sub/booth multiply/restoring divide unit
//
//  channel  | transfer when        | ports
//  ---------+----------------------+------------------------------------------
//  command  | start && !busy       | in_func, in_operand_a, in_operand_b
//  result   | out_strobe           | out_result, out_remainder, out_overflow
//
// one command per cycle; every operation is written into the fifo and then passes a
// WIDTH-stage step pipeline, so a result reaches the ports through the fifo entry
// and then the WIDTH stage registers, the last of which drives the result ports
// busy reports a full fifo; the pipeline takes one entry a cycle, so it never rises
// results cannot be held off; each is on the ports for a single cycle
// synchronous active-low reset empties the fifo and clears all stage valids
`default_nettype none

module add_sub_booth_mul_restoring_div_unit #(
  parameter int WIDTH = asbmd_pkg::WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_func,
  input  wire logic [WIDTH-1:0]   in_operand_a,
  input  wire logic [WIDTH-1:0]   in_operand_b,
  output logic                    out_strobe,
  output logic [WIDTH-1:0]        out_result,
  output logic [WIDTH-1:0]        out_remainder,
  output logic                    out_overflow
);
  import asbmd_pkg::*;

  logic             q_full;
  logic             push;
  ctl_t             push_ctl;
  logic [WIDTH-1:0] push_acc;
  logic [WIDTH-1:0] push_mq;
  logic [WIDTH-1:0] push_bop;
  logic             pop;
  ctl_t             pop_ctl;
  logic [WIDTH-1:0] pop_acc;
  logic [WIDTH-1:0] pop_mq;
  logic [WIDTH-1:0] pop_bop;

  asbmd_front #(
    .WIDTH (WIDTH)
  ) u_front (
    .start        (start),
    .q_full       (q_full),
    .in_func      (in_func),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .busy         (busy),
    .push         (push),
    .push_ctl     (push_ctl),
    .push_acc     (push_acc),
    .push_mq      (push_mq),
    .push_bop     (push_bop)
  );

  asbmd_queue #(
    .WIDTH (WIDTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ctl (push_ctl),
    .push_acc (push_acc),
    .push_mq  (push_mq),
    .push_bop (push_bop),
    .full     (q_full),
    .pop      (pop),
    .pop_ctl  (pop_ctl),
    .pop_acc  (pop_acc),
    .pop_mq   (pop_mq),
    .pop_bop  (pop_bop)
  );

  asbmd_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (pop),
    .in_ctl        (pop_ctl),
    .in_acc        (pop_acc),
    .in_mq         (pop_mq),
    .in_bop        (pop_bop),
    .out_strobe    (out_strobe),
    .out_result    (out_result),
    .out_remainder (out_remainder),
    .out_overflow  (out_overflow)
  );

endmodule

`default_nettype wire
